### design/gfm_pkg.sv
package gfm_pkg;

    // Flow table geometry; entries and ways are powers of two
    localparam int TABLE_ENTRIES = 65536;
    localparam int TABLE_WAYS    = 4;
    localparam int NUM_BUCKETS   = TABLE_ENTRIES / TABLE_WAYS;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int BUCKET_W      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int WAY_W         = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;

    localparam logic [63:0] HASH_INIT = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] HASH_MUL  = 64'hBF58476D1CE4E5B9;

    localparam logic [15:0] GENEVE_PORT_RST = 16'd6081;
    localparam logic [7:0]  GENEVE_SKIP_RST = 8'd8;

    localparam logic [7:0] CFG_GENEVE_PORT = 8'd0;
    localparam logic [7:0] CFG_GENEVE_SKIP = 8'd1;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] ETYPE_HI  = 8'h08;

    // captured meta bits
    localparam int M_ENCAP    = 9;
    localparam int M_OUTER_IP = 10;
    localparam int M_INNER_IP = 11;

    typedef enum logic [1:0] {
        ST_UPDATED   = 2'd0,
        ST_NEW       = 2'd1,
        ST_UNTRACKED = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_MIX,
        S_RD,
        S_CHK,
        S_WR
    } t_state;

    // header capture of the packet in progress
    typedef struct packed {
        logic [63:0] outer_addrs;
        logic [63:0] inner_addrs;
        logic [31:0] ports;
        logic [11:0] meta;
        logic [7:0]  l4_flags;
        logic [8:0]  inner_start;
        logic [16:0] len;
    } t_capture;

    typedef struct packed {
        logic [11:0] meta;
        logic [63:0] addrs;
        logic [31:0] ports;
        logic [7:0]  flags;
    } t_frame;

    typedef struct packed {
        logic        valid;
        logic [63:0] outer_key;
        logic [63:0] inner_key;
        logic [31:0] port_key;
        logic [9:0]  meta_key;
        logic [63:0] packets;
        logic [63:0] bytes;
        logic [63:0] first_seen;
        logic [63:0] last_seen;
        logic [7:0]  flags;
    } t_entry;

endpackage

### design/gfm_parser.sv
module gfm_parser import gfm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_clear,
    input  logic [15:0] i_geneve_port,
    input  logic [7:0]  i_geneve_skip,
    output t_capture    o_cap
);

    logic [15:0] r_off, n_off;
    logic [63:0] r_outer, n_outer;
    logic [63:0] r_inner, n_inner;
    logic [31:0] r_ports, n_ports;
    logic [11:0] r_meta, n_meta;
    logic [7:0]  r_flags, n_flags;
    logic [8:0]  r_start, n_start;

    function automatic t_frame frame_upd(t_frame s, logic [15:0] rr, logic [7:0] b,
                                         logic inner);
        t_frame t;
        int     ip;
        t  = s;
        ip = inner ? M_INNER_IP : M_OUTER_IP;
        if (rr == 16'd12) t.meta[ip] = (b == ETYPE_HI);
        if (rr == 16'd13 && b != 8'd0) t.meta[ip] = 1'b0;
        if (rr == 16'd23) t.meta[7:0] = b;
        if (rr >= 16'd26 && rr <= 16'd33) t.addrs = {t.addrs[55:0], b};
        if (rr >= 16'd34 && rr <= 16'd37) t.ports = {t.ports[23:0], b};
        if (rr == 16'd47 && t.meta[7:0] == PROTO_TCP) t.flags = b;
        return t;
    endfunction

    always_comb begin
        t_frame s;
        logic   enc;
        enc     = r_meta[M_ENCAP];
        s       = '{meta: r_meta, addrs: r_outer, ports: r_ports, flags: r_flags};
        n_start = r_start;
        n_inner = r_inner;
        if (!enc || r_off < 16'd47) begin
            s = frame_upd(s, r_off, i_data_byte, 1'b0);
        end
        n_outer = s.addrs;
        if (r_off == 16'd37 && s.meta[M_OUTER_IP] && s.meta[7:0] == PROTO_UDP &&
            s.ports[15:0] == i_geneve_port) begin
            s.meta[M_ENCAP] = 1'b1;
            n_start = 9'd42 + {1'b0, i_geneve_skip};
        end
        if (enc && r_off >= {7'd0, r_start}) begin
            s.addrs = r_inner;
            s = frame_upd(s, r_off - {7'd0, r_start}, i_data_byte, 1'b1);
            n_inner = s.addrs;
        end
        n_meta  = s.meta;
        n_ports = s.ports;
        n_flags = s.flags;
        if (i_last_byte || r_off == 16'hFFFF) begin
            n_off = r_off;
        end else begin
            n_off = r_off + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_off   <= '0;
            r_outer <= '0;
            r_inner <= '0;
            r_ports <= '0;
            r_meta  <= '0;
            r_flags <= '0;
            r_start <= '0;
        end else if (i_take) begin
            r_off   <= n_off;
            r_outer <= n_outer;
            r_inner <= n_inner;
            r_ports <= n_ports;
            r_meta  <= n_meta;
            r_flags <= n_flags;
            r_start <= n_start;
        end
    end

    assign o_cap.outer_addrs = r_outer;
    assign o_cap.inner_addrs = r_inner;
    assign o_cap.ports       = r_ports;
    assign o_cap.meta        = r_meta;
    assign o_cap.l4_flags    = r_flags;
    assign o_cap.inner_start = r_start;
    assign o_cap.len         = {1'b0, r_off} + 17'd1;

endmodule

### design/geneve_flow_meter.sv
// Flow meter for IPv4 TCP/UDP, native or carried in GENEVE. Bytes enter one per
// cycle while o_busy is low. After the last byte o_busy stays high while the flow
// is resolved: when the packet is not tracked only the checks run, otherwise the
// checks, then key hashing (4 words on one shared 32x32 multiplier), then a read
// and a check per way of the bucket in the flow table until a match or the last
// way, and a final write. The result is shown for one cycle with o_valid and
// cannot be held off. After reset all TABLE_ENTRIES (65536) entries are swept
// clean with o_busy high; configuration writes are taken at any time.
module geneve_flow_meter import gfm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_direction,
    input  logic [63:0] i_timestamp_ns,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_outer_saddr,
    output logic [31:0] o_outer_daddr,
    output logic [31:0] o_inner_saddr,
    output logic [31:0] o_inner_daddr,
    output logic [15:0] o_src_port,
    output logic [15:0] o_dst_port,
    output logic [7:0]  o_protocol,
    output logic        o_flow_direction,
    output logic        o_encapsulated,
    output logic [63:0] o_packet_count,
    output logic [63:0] o_byte_count
);

    t_state      r_state, n_state;
    logic [15:0] r_cfg_port;
    logic [7:0]  r_cfg_skip;
    t_capture    cap;
    logic        accept, clear, track;

    logic        r_dir;
    logic [63:0] r_ts;
    logic [63:0] r_ok, r_ik;
    logic [31:0] r_pk;
    logic [9:0]  r_mk;
    logic [7:0]  r_fl;
    logic [16:0] r_len;

    logic [63:0] r_h, r_x, r_prod, r_acc, mix_word, mixed;
    logic [2:0]  r_phase;
    logic [1:0]  r_mix;
    logic [31:0] mul_a, mul_b;

    logic [WAY_W-1:0]  r_way, r_free_way;
    logic              r_free_vld, r_hit;
    logic [ADDR_W-1:0] r_clr, rd_addr, free_addr, base;
    t_entry            r_ent, r_rdata, wr_ent;
    t_entry            r_mem [TABLE_ENTRIES];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_entry            mem_wdata;
    logic              match, last_way;

    gfm_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (accept),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_clear       (clear),
        .i_geneve_port (r_cfg_port),
        .i_geneve_skip (r_cfg_skip),
        .o_cap         (cap)
    );

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_port <= GENEVE_PORT_RST;
            r_cfg_skip <= GENEVE_SKIP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GENEVE_PORT: r_cfg_port <= i_cfg_wdata;
                CFG_GENEVE_SKIP: r_cfg_skip <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // track decision on the finished capture
    always_comb begin
        logic [7:0]  proto;
        logic [16:0] s;
        proto = cap.meta[7:0];
        s     = {8'd0, cap.inner_start};
        track = 1'b0;
        if (cap.meta[M_OUTER_IP] && cap.len >= 17'd34) begin
            if (!cap.meta[M_ENCAP]) begin
                track = (proto == PROTO_TCP && cap.len >= 17'd54) ||
                        (proto == PROTO_UDP && cap.len >= 17'd42);
            end else begin
                track = cap.meta[M_INNER_IP] && cap.len >= s + 17'd34 &&
                        ((proto == PROTO_TCP && cap.len >= s + 17'd54) ||
                         (proto == PROTO_UDP && cap.len >= s + 17'd42));
            end
        end
    end

    // hash: one 32x32 partial product per cycle
    always_comb begin
        case (r_mix)
            2'd0:    mix_word = r_ok;
            2'd1:    mix_word = r_ik;
            2'd2:    mix_word = {32'd0, r_pk};
            default: mix_word = {54'd0, r_mk};
        endcase
        case (r_phase)
            3'd1:    begin mul_a = r_x[31:0];  mul_b = HASH_MUL[31:0];  end
            3'd2:    begin mul_a = r_x[31:0];  mul_b = HASH_MUL[63:32]; end
            default: begin mul_a = r_x[63:32]; mul_b = HASH_MUL[31:0];  end
        endcase
        mixed = {r_acc[63:32] + r_prod[31:0], r_acc[31:0]};
    end

    assign base      = ADDR_W'(r_h[32 +: BUCKET_W]) * ADDR_W'(TABLE_WAYS);
    assign rd_addr   = base + ADDR_W'(r_way);
    assign free_addr = base + ADDR_W'(r_free_way);
    assign last_way  = (r_way == WAY_W'(TABLE_WAYS - 1));
    assign match     = r_rdata.valid && r_rdata.outer_key == r_ok &&
                       r_rdata.inner_key == r_ik && r_rdata.port_key == r_pk &&
                       r_rdata.meta_key == r_mk;

    always_comb begin
        wr_ent = r_ent;
        if (r_hit) begin
            wr_ent.packets   = r_ent.packets + 64'd1;
            wr_ent.bytes     = r_ent.bytes + {47'd0, r_len};
            wr_ent.last_seen = r_ts;
            wr_ent.flags     = r_ent.flags | r_fl;
        end else begin
            wr_ent.valid      = 1'b1;
            wr_ent.outer_key  = r_ok;
            wr_ent.inner_key  = r_ik;
            wr_ent.port_key   = r_pk;
            wr_ent.meta_key   = r_mk;
            wr_ent.packets    = 64'd1;
            wr_ent.bytes      = {47'd0, r_len};
            wr_ent.first_seen = r_ts;
            wr_ent.last_seen  = r_ts;
            wr_ent.flags      = r_fl;
        end
    end

    always_comb begin
        n_state   = r_state;
        clear     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr == ADDR_W'(TABLE_ENTRIES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept && i_last_byte) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (track) begin
                    n_state = S_MIX;
                end else begin
                    clear   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MIX: begin
                if (r_phase == 3'd4 && r_mix == 2'd3) n_state = S_RD;
            end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                if (match || last_way) n_state = S_WR;
                else n_state = S_RD;
            end
            S_WR: begin
                clear     = 1'b1;
                mem_we    = r_hit || r_free_vld;
                mem_waddr = r_hit ? rd_addr : free_addr;
                mem_wdata = wr_ent;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            o_valid <= (r_state == S_EVAL && !track) || r_state == S_WR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_dir <= i_direction;
            r_ts  <= i_timestamp_ns;
        end
        r_prod <= {32'd0, mul_a} * {32'd0, mul_b};
        case (r_state)
            S_EVAL: begin
                r_ok    <= cap.outer_addrs;
                r_ik    <= cap.meta[M_ENCAP] ? cap.inner_addrs : cap.outer_addrs;
                r_pk    <= cap.ports;
                r_mk    <= {cap.meta[M_ENCAP], r_dir, cap.meta[7:0]};
                r_fl    <= (cap.meta[7:0] == PROTO_TCP) ? cap.l4_flags : 8'd0;
                r_len   <= cap.len;
                r_h     <= HASH_INIT;
                r_phase <= 3'd0;
                r_mix   <= 2'd0;
                if (!track) begin
                    o_status         <= ST_UNTRACKED;
                    o_outer_saddr    <= '0;
                    o_outer_daddr    <= '0;
                    o_inner_saddr    <= '0;
                    o_inner_daddr    <= '0;
                    o_src_port       <= '0;
                    o_dst_port       <= '0;
                    o_protocol       <= '0;
                    o_flow_direction <= 1'b0;
                    o_encapsulated   <= 1'b0;
                    o_packet_count   <= '0;
                    o_byte_count     <= '0;
                end
            end
            S_MIX: begin
                case (r_phase)
                    3'd0: r_x <= r_h ^ mix_word;
                    3'd2: r_acc <= r_prod;
                    3'd3: r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                    3'd4: r_h <= mixed ^ (mixed >> 31);
                    default: ;
                endcase
                if (r_phase == 3'd4) begin
                    r_phase <= 3'd0;
                    r_mix   <= r_mix + 2'd1;
                end else begin
                    r_phase <= r_phase + 3'd1;
                end
                r_way      <= '0;
                r_free_vld <= 1'b0;
                r_hit      <= 1'b0;
            end
            S_CHK: begin
                if (match) begin
                    r_hit <= 1'b1;
                    r_ent <= r_rdata;
                end else begin
                    if (!r_rdata.valid && !r_free_vld) begin
                        r_free_vld <= 1'b1;
                        r_free_way <= r_way;
                    end
                    if (!last_way) r_way <= r_way + 1'b1;
                end
            end
            S_WR: begin
                o_outer_saddr    <= r_ok[63:32];
                o_outer_daddr    <= r_ok[31:0];
                o_inner_saddr    <= r_ik[63:32];
                o_inner_daddr    <= r_ik[31:0];
                o_src_port       <= r_pk[31:16];
                o_dst_port       <= r_pk[15:0];
                o_protocol       <= r_mk[7:0];
                o_flow_direction <= r_mk[8];
                o_encapsulated   <= r_mk[9];
                if (r_hit || r_free_vld) begin
                    o_status       <= r_hit ? ST_UPDATED : ST_NEW;
                    o_packet_count <= wr_ent.packets;
                    o_byte_count   <= wr_ent.bytes;
                end else begin
                    o_status       <= ST_FULL;
                    o_packet_count <= '0;
                    o_byte_count   <= '0;
                end
            end
            default: ;
        endcase
    end

    // a result always returns the block to idle, so strobes never repeat
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result strobes");

    a_untracked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_UNTRACKED) |-> (o_packet_count == '0 &&
            o_byte_count == '0 && o_protocol == '0))
        else $error("untracked result with nonzero fields");

    a_new_flow_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NEW) |-> o_packet_count == 64'd1)
        else $error("new flow without a packet count of one");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX || r_state == S_RD || r_state == S_CHK) |-> !accept)
        else $error("byte taken during table work");

endmodule

### tb/geneve_flow_meter_tb.sv
module geneve_flow_meter_tb import gfm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CFG_NONE = 8'hFF;   // unmapped register index
    localparam int POOL_SIZE = 6;

    typedef struct {
        bit [7:0]  data;
        bit        last;
        bit        dir;
        bit [63:0] ts;
    } t_item;

    typedef struct {
        t_status   status;
        bit [31:0] outer_src, outer_dst, inner_src, inner_dst;
        bit [15:0] sport, dport;
        bit [7:0]  proto;
        bit        dir, encap;
        bit [63:0] pkts, bytes;
    } t_meter_rec;

    typedef struct {
        bit        encap;
        bit        dir;
        bit [7:0]  proto;
        bit [31:0] os, od, is, id;
        bit [15:0] sp, dp;
    } t_flow;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_start = 0;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 0;
    logic        i_direction = 0;
    logic [63:0] i_timestamp_ns = '0;
    logic        i_cfg_we = 0;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        o_busy, o_valid;
    logic [1:0]  o_status;
    logic [31:0] o_outer_saddr, o_outer_daddr, o_inner_saddr, o_inner_daddr;
    logic [15:0] o_src_port, o_dst_port;
    logic [7:0]  o_protocol;
    logic        o_flow_direction, o_encapsulated;
    logic [63:0] o_packet_count, o_byte_count;

    geneve_flow_meter u_dut (.*);

    always #5 i_clk = ~i_clk;

    t_item      byte_q[$];
    t_meter_rec meter_q[$];
    int         errors = 0;

    // predictor state
    bit [15:0] cfg_port = GENEVE_PORT_RST;
    bit [7:0]  cfg_skip = GENEVE_SKIP_RST;
    int        offset;
    bit [63:0] outer_a, inner_a;
    bit [31:0] ports;
    bit [11:0] meta;
    bit [7:0]  tflags;
    int        istart;
    bit        fv[int];
    bit [63:0] f_ok[int], f_ik[int], f_pkts[int], f_bytes[int];
    bit [31:0] f_pk[int];
    bit [9:0]  f_mk[int];

    function automatic void clear_capture();
        offset = 0; outer_a = 0; inner_a = 0; ports = 0; meta = 0; tflags = 0; istart = 0;
    endfunction

    function automatic bit [63:0] mix_word(bit [63:0] h, bit [63:0] w);
        h ^= w;
        h = h * HASH_MUL;
        return h ^ (h >> 31);
    endfunction

    function automatic int bucket_of(bit [63:0] ok, bit [63:0] ik, bit [31:0] pk,
                                     bit [9:0] mk);
        bit [63:0] h;
        h = mix_word(HASH_INIT, ok);
        h = mix_word(h, ik);
        h = mix_word(h, 64'(pk));
        h = mix_word(h, 64'(mk));
        return int'((h >> 32) % 64'(NUM_BUCKETS));
    endfunction

    function automatic void frame_byte(int r, bit [7:0] b, int ipb, bit inner);
        if (r == 12) meta[ipb] = (b == ETYPE_HI);
        if (r == 13 && b != 0) meta[ipb] = 0;
        if (r == 23) meta[7:0] = b;
        if (r >= 26 && r <= 33) begin
            if (inner) inner_a = {inner_a[55:0], b};
            else outer_a = {outer_a[55:0], b};
        end
        if (r >= 34 && r <= 37) ports = {ports[23:0], b};
        if (r == 47 && meta[7:0] == PROTO_TCP) tflags = b;
    endfunction

    function automatic void meter_item(t_item it);
        int o, len, base, idx, hit, free_w;
        bit enc, trk;
        bit [7:0] proto;
        bit [9:0] mk;
        t_meter_rec e;
        o = offset;
        enc = meta[M_ENCAP];
        if (!enc || o < 47) frame_byte(o, it.data, M_OUTER_IP, 1'b0);
        if (o == 37 && meta[M_OUTER_IP] && meta[7:0] == PROTO_UDP && ports[15:0] == cfg_port)
        begin
            meta[M_ENCAP] = 1;
            istart = 42 + cfg_skip;
        end
        if (enc && o >= istart) frame_byte(o - istart, it.data, M_INNER_IP, 1'b1);
        if (!it.last) begin
            if (offset < 65535) offset++;
            return;
        end
        len = o + 1;
        proto = meta[7:0];
        enc = meta[M_ENCAP];
        trk = 0;
        if (meta[M_OUTER_IP] && len >= 34) begin
            if (!enc) begin
                trk = (proto == PROTO_TCP && len >= 54) || (proto == PROTO_UDP && len >= 42);
                inner_a = outer_a;
            end else begin
                trk = meta[M_INNER_IP] && len >= istart + 34 &&
                      ((proto == PROTO_TCP && len >= istart + 54) ||
                       (proto == PROTO_UDP && len >= istart + 42));
            end
        end
        e = '{status: ST_UNTRACKED, default: 0};
        if (trk) begin
            mk = {enc, it.dir, proto};
            base = bucket_of(outer_a, inner_a, ports, mk) * TABLE_WAYS;
            hit = -1;
            free_w = -1;
            for (int w = 0; w < TABLE_WAYS; w++) begin
                idx = base + w;
                if (fv.exists(idx)) begin
                    if (hit < 0 && f_ok[idx] == outer_a && f_ik[idx] == inner_a &&
                        f_pk[idx] == ports && f_mk[idx] == mk) hit = w;
                end else if (free_w < 0) begin
                    free_w = w;
                end
            end
            e.outer_src = outer_a[63:32]; e.outer_dst = outer_a[31:0];
            e.inner_src = inner_a[63:32]; e.inner_dst = inner_a[31:0];
            e.sport = ports[31:16]; e.dport = ports[15:0];
            e.proto = proto; e.dir = it.dir; e.encap = enc;
            if (hit >= 0) begin
                idx = base + hit;
                f_pkts[idx] += 1;
                f_bytes[idx] += 64'(len);
                e.status = ST_UPDATED;
            end else if (free_w >= 0) begin
                idx = base + free_w;
                fv[idx] = 1;
                f_ok[idx] = outer_a; f_ik[idx] = inner_a; f_pk[idx] = ports; f_mk[idx] = mk;
                f_pkts[idx] = 1;
                f_bytes[idx] = 64'(len);
                e.status = ST_NEW;
            end else begin
                e.status = ST_FULL;
            end
            if (e.status != ST_FULL) begin
                e.pkts = f_pkts[idx];
                e.bytes = f_bytes[idx];
            end
        end
        meter_q.push_back(e);
        clear_capture();
    endfunction

    // driver: bursts of items with random gaps
    t_item cur;
    int    burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 0;
        end else begin
            if (i_start && !o_busy) meter_item(cur);
            if (i_start && o_busy) begin
                // hold the item
            end else if (gap_left > 0) begin
                gap_left--;
                i_start <= 0;
            end else if (byte_q.size() > 0) begin
                cur = byte_q.pop_front();
                i_data_byte <= cur.data;
                i_last_byte <= cur.last;
                i_direction <= cur.dir;
                i_timestamp_ns <= cur.ts;
                i_start <= 1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_start <= 0;
            end
        end
    end

    function automatic void cmp(string nm, bit [63:0] e, logic [63:0] a);
        if (a !== e) begin
            $display("%0t %s mismatch: expected %h actual %h", $time, nm, e, a);
            errors++;
        end
    endfunction

    // monitor
    always @(posedge i_clk) begin
        t_meter_rec e;
        if (i_rst_n && o_valid) begin
            if (meter_q.size() == 0) begin
                $display("%0t unexpected result: status %h", $time, o_status);
                errors++;
            end else begin
                e = meter_q.pop_front();
                cmp("status", e.status, o_status);
                cmp("outer_saddr", e.outer_src, o_outer_saddr);
                cmp("outer_daddr", e.outer_dst, o_outer_daddr);
                cmp("inner_saddr", e.inner_src, o_inner_saddr);
                cmp("inner_daddr", e.inner_dst, o_inner_daddr);
                cmp("src_port", e.sport, o_src_port);
                cmp("dst_port", e.dport, o_dst_port);
                cmp("protocol", e.proto, o_protocol);
                cmp("flow_direction", e.dir, o_flow_direction);
                cmp("encapsulated", e.encap, o_encapsulated);
                cmp("packet_count", e.pkts, o_packet_count);
                cmp("byte_count", e.bytes, o_byte_count);
            end
        end
    end

    // packet building
    function automatic void put_frame(ref bit [7:0] q[$], input bit [15:0] et,
                                      input bit [7:0] pr, input bit [31:0] s, d,
                                      input bit [15:0] sp, dp, input bit [7:0] fl);
        repeat (12) q.push_back(8'($urandom));
        q.push_back(et[15:8]);
        q.push_back(et[7:0]);
        for (int i = 0; i < 20; i++) begin
            case (i)
                0: q.push_back(8'h45);
                9: q.push_back(pr);
                12, 13, 14, 15: q.push_back(s[8*(15-i) +: 8]);
                16, 17, 18, 19: q.push_back(d[8*(19-i) +: 8]);
                default: q.push_back(8'($urandom));
            endcase
        end
        q.push_back(sp[15:8]); q.push_back(sp[7:0]);
        q.push_back(dp[15:8]); q.push_back(dp[7:0]);
        if (pr == PROTO_TCP) begin
            repeat (9) q.push_back(8'($urandom));
            q.push_back(fl);
            repeat (6) q.push_back(8'($urandom));
        end else begin
            repeat (4) q.push_back(8'($urandom));
        end
    endfunction

    function automatic void send(ref bit [7:0] q[$], input bit dir, input int cut);
        int n;
        n = (cut > 0 && cut < q.size()) ? cut : q.size();
        for (int i = 0; i < n; i++)
            byte_q.push_back('{q[i], i == n - 1, dir, {$urandom, $urandom}});
    endfunction

    function automatic void send_flow(t_flow f, int payload, int cut, bit [15:0] in_et);
        bit [7:0] q[$];
        if (f.encap) begin
            put_frame(q, 16'h0800, PROTO_UDP, f.os, f.od, 16'($urandom), cfg_port, 8'd0);
            repeat (cfg_skip) q.push_back(8'($urandom));
            put_frame(q, in_et, f.proto, f.is, f.id, f.sp, f.dp, 8'($urandom));
        end else begin
            put_frame(q, in_et, f.proto, f.os, f.od, f.sp, f.dp, 8'($urandom));
        end
        repeat (payload) q.push_back(8'($urandom));
        send(q, f.dir, cut);
    endfunction

    function automatic bit [31:0] pick_addr();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_flow new_flow();
        t_flow f;
        f.encap = 1'($urandom_range(0, 1));
        f.dir = 1'($urandom_range(0, 1));
        f.proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
        f.os = pick_addr(); f.od = pick_addr(); f.is = pick_addr(); f.id = pick_addr();
        f.sp = 16'($urandom); f.dp = 16'($urandom);
        return f;
    endfunction

    t_flow pool[POOL_SIZE];

    task automatic rand_packets(int n);
        int r, k;
        bit [7:0] q[$];
        t_flow f;
        for (int i = 0; i < POOL_SIZE; i++) pool[i] = new_flow();
        repeat (n) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, POOL_SIZE - 1);
            if (r < 70) begin
                send_flow(pool[k], $urandom_range(0, 16),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(1, 120) : 0, 16'h0800);
            end else if (r < 82) begin
                pool[k] = new_flow();
                send_flow(pool[k], $urandom_range(0, 8), 0, 16'h0800);
            end else if (r < 90) begin
                f = new_flow();
                f.proto = $urandom_range(0, 3) ? 8'($urandom) : PROTO_TCP;
                send_flow(f, $urandom_range(0, 8), 0,
                          $urandom_range(0, 1) ? 16'($urandom) : 16'h0801);
            end else begin
                q.delete();
                repeat ($urandom_range(1, 70)) q.push_back(8'($urandom));
                send(q, 1'($urandom_range(0, 1)), 0);
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (byte_q.size() > 0 || i_start || meter_q.size() > 0 || o_busy);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(bit [7:0] idx, bit [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_GENEVE_PORT) cfg_port = val;
        else if (idx == CFG_GENEVE_SKIP) cfg_skip = val[7:0];
    endtask

    initial begin
        t_flow f, g;
        t_flow coll[$];
        bit [7:0] q[$];
        int bkt;
        clear_capture();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // bucket collision: four ways fill, the fifth finds the bucket full
        f = new_flow();
        f.encap = 0; f.proto = PROTO_UDP; f.dp = 16'd53;
        bkt = bucket_of({f.os, f.od}, {f.os, f.od}, {f.sp, f.dp}, {1'b0, f.dir, f.proto});
        coll.push_back(f);
        while (coll.size() < 5) begin
            g = f;
            g.sp = 16'($urandom); g.dp = 16'($urandom);
            if (g.dp != cfg_port && {g.sp, g.dp} != {f.sp, f.dp} &&
                bucket_of({g.os, g.od}, {g.os, g.od}, {g.sp, g.dp},
                          {1'b0, g.dir, g.proto}) == bkt)
                coll.push_back(g);
        end
        foreach (coll[i]) send_flow(coll[i], 0, 0, 16'h0800);
        send_flow(coll[0], 3, 0, 16'h0800);

        // minimal lengths and their one-short variants, then untracked non-IPv4, ICMP and one-byte packets
        f = new_flow(); f.encap = 0; f.proto = PROTO_TCP; f.dp = 16'd80;
        f.os = 32'hFFFF_FFFF; f.od = 32'h0;
        send_flow(f, 0, 0, 16'h0800);
        send_flow(f, 0, 53, 16'h0800);
        f.dir = ~f.dir;
        send_flow(f, 0, 0, 16'h0800);
        f.proto = PROTO_UDP; f.sp = 16'hFFFF; f.dp = 16'h0;
        send_flow(f, 0, 0, 16'h0800);
        send_flow(f, 0, 41, 16'h0800);
        send_flow(f, 0, 34, 16'h0800);
        send_flow(f, 0, 0, 16'h86DD);
        send_flow(f, 0, 0, 16'h0801);
        f.proto = 8'd1;
        send_flow(f, 4, 0, 16'h0800);
        q.push_back(8'($urandom));
        send(q, 1'b1, 0);
        // GENEVE with inner TCP, UDP, non-IPv4 inner, and a short inner frame
        f = new_flow(); f.encap = 1; f.proto = PROTO_TCP;
        send_flow(f, 2, 0, 16'h0800);
        send_flow(f, 0, 0, 16'h0800);
        f.proto = PROTO_UDP;
        send_flow(f, 0, 0, 16'h0800);
        send_flow(f, 0, 0, 16'h0806);
        send_flow(f, 0, 42 + cfg_skip + 41, 16'h0800);
        wait_idle();

        rand_packets(3);
        wait_idle();
        cfg_write(CFG_GENEVE_PORT, 16'h0000);
        cfg_write(CFG_GENEVE_SKIP, 16'h0000);
        cfg_write(CFG_NONE, 16'hFFFF);
        rand_packets(2);
        wait_idle();
        cfg_write(CFG_GENEVE_PORT, 16'hFFFF);
        cfg_write(CFG_GENEVE_SKIP, 16'h00FF);
        rand_packets(1);
        wait_idle();
        cfg_write(CFG_GENEVE_PORT, 16'($urandom));
        cfg_write(CFG_GENEVE_SKIP, 16'($urandom_range(0, 20)));
        rand_packets(2);
        wait_idle();
        cfg_write(CFG_GENEVE_PORT, GENEVE_PORT_RST);
        cfg_write(CFG_GENEVE_SKIP, 16'(GENEVE_SKIP_RST));
        rand_packets(1);
        wait_idle();

        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
